[hdl/nsfs_pkg.sv]
package nsfs_pkg;

	localparam int DEFAULT_MAX_FIELDS = 32;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_CHECK = 8'h2A;
	localparam logic [7:0] CH_SEP   = 8'h2C;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_NO_START,
		ERR_START_INSIDE,
		ERR_CHECKSUM_TRUNC,
		ERR_NON_HEX,
		ERR_TOO_MANY
	} err_t;

	typedef struct packed {
		logic        field_done;
		logic [4:0]  field_number;
		logic [15:0] field_start;
		logic [7:0]  field_length;
		logic        sentence_done;
		logic        parse_ok;
		err_t        error_code;
		logic [4:0]  last_field_index;
		logic [7:0]  received_sum;
		logic [7:0]  computed_sum;
	} result_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			n = b[3:0];
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			// low nibble of 'A'/'a' is 1, so +9 gives 10
			n = b[3:0] + 4'd9;
		end
		return n;
	endfunction

endpackage

[hdl/nsfs_core.sv]
module nsfs_core
	import nsfs_pkg::*;
#(
	parameter int MAX_FIELDS = DEFAULT_MAX_FIELDS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	output logic       has_result,
	output result_t    res
);

	localparam int FW = $clog2(MAX_FIELDS + 1);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_DIGIT_HI,
		PH_DIGIT_LO,
		PH_DROP
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  captured_q, captured_d;
	logic [7:0]  decoded_q, decoded_d;
	logic [3:0]  upper_q, upper_d;
	logic        invalid_q, invalid_d;
	logic [FW-1:0] field_q, field_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] start_q, start_d;
	logic [15:0] offset_q, offset_d;

	logic [15:0] off_inc;
	logic [FW:0] field_inc;
	logic [FW+4:0] fn_ext, last_ext;
	logic        fd, sd;
	err_t        err;

	always_comb begin
		phase_d    = phase_q;
		xor_d      = xor_q;
		captured_d = captured_q;
		decoded_d  = decoded_q;
		upper_d    = upper_q;
		invalid_d  = invalid_q;
		field_d    = field_q;
		len_d      = len_q;
		start_d    = start_q;
		fd         = 1'b0;
		sd         = 1'b0;
		err        = ERR_NONE;
		off_inc    = (offset_q == 16'hFFFF) ? offset_q : offset_q + 16'd1;
		field_inc  = {1'b0, field_q} + {{FW{1'b0}}, 1'b1};

		unique case (phase_q)
			PH_HUNT: begin
				if (data_byte == CH_START) begin
					xor_d      = 8'd0;
					captured_d = 8'hFF;
					decoded_d  = 8'd0;
					upper_d    = 4'd0;
					invalid_d  = 1'b0;
					field_d    = '0;
					len_d      = 8'd0;
					start_d    = off_inc;
					phase_d    = PH_PAYLOAD;
					sd         = end_of_buffer;
				end else if (end_of_buffer) begin
					sd  = 1'b1;
					err = ERR_NO_START;
				end
			end
			PH_PAYLOAD: begin
				if (data_byte == CH_START) begin
					sd  = 1'b1;
					err = ERR_START_INSIDE;
				end else if (data_byte == CH_CHECK) begin
					fd = 1'b1;
					if (end_of_buffer) begin
						sd  = 1'b1;
						err = ERR_CHECKSUM_TRUNC;
					end else begin
						phase_d = PH_DIGIT_HI;
					end
				end else if (data_byte == CH_SEP) begin
					fd    = 1'b1;
					xor_d = xor_q ^ data_byte;
					if (end_of_buffer) begin
						sd = 1'b1;
					end else if (field_inc >= (FW+1)'(MAX_FIELDS)) begin
						field_d = FW'(MAX_FIELDS);
						sd      = 1'b1;
						err     = ERR_TOO_MANY;
					end else begin
						field_d = field_inc[FW-1:0];
						start_d = off_inc;
						len_d   = 8'd0;
					end
				end else begin
					len_d = (len_q == 8'hFF) ? len_q : len_q + 8'd1;
					xor_d = xor_q ^ data_byte;
					sd    = end_of_buffer;
				end
			end
			PH_DIGIT_HI: begin
				if (end_of_buffer) begin
					sd  = 1'b1;
					err = ERR_CHECKSUM_TRUNC;
				end else begin
					upper_d   = nibble_of(data_byte);
					invalid_d = !is_hex(data_byte);
					phase_d   = PH_DIGIT_LO;
				end
			end
			PH_DIGIT_LO: begin
				if (end_of_buffer) begin
					sd  = 1'b1;
					err = ERR_CHECKSUM_TRUNC;
				end else if (invalid_q || !is_hex(data_byte)) begin
					sd  = 1'b1;
					err = ERR_NON_HEX;
				end else begin
					decoded_d  = {upper_q, nibble_of(data_byte)};
					captured_d = xor_q;
					// second digit goes into the running sum after capture
					xor_d      = xor_q ^ data_byte;
					phase_d    = PH_PAYLOAD;
				end
			end
			PH_DROP: begin
			end
			default: begin
			end
		endcase

		if (sd && err != ERR_NONE) begin
			phase_d = PH_DROP;
		end
		if (end_of_buffer) begin
			phase_d  = PH_HUNT;
			offset_d = 16'd0;
		end else begin
			offset_d = off_inc;
		end

		fn_ext   = {5'd0, field_q};
		last_ext = {5'd0, field_d};

		has_result           = fd || sd;
		res.field_done       = fd;
		res.field_number     = fd ? fn_ext[4:0] : 5'd0;
		res.field_start      = fd ? start_q : 16'd0;
		res.field_length     = fd ? len_q : 8'd0;
		res.sentence_done    = sd;
		res.parse_ok         = sd && err == ERR_NONE;
		res.error_code       = err;
		res.last_field_index = sd ? last_ext[4:0] : 5'd0;
		res.received_sum     = sd ? decoded_d : 8'd0;
		res.computed_sum     = sd ? captured_d : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			xor_q      <= 8'd0;
			captured_q <= 8'hFF;
			decoded_q  <= 8'd0;
			upper_q    <= 4'd0;
			invalid_q  <= 1'b0;
			field_q    <= '0;
			len_q      <= 8'd0;
			start_q    <= 16'd0;
			offset_q   <= 16'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			xor_q      <= xor_d;
			captured_q <= captured_d;
			decoded_q  <= decoded_d;
			upper_q    <= upper_d;
			invalid_q  <= invalid_d;
			field_q    <= field_d;
			len_q      <= len_d;
			start_q    <= start_d;
			offset_q   <= offset_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FW'(MAX_FIELDS))
		else $error("field counter beyond limit");

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_DROP && !end_of_buffer |=> phase_q == PH_DROP)
		else $error("left drop phase before end of buffer");

	a_eob_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_buffer |=> phase_q == PH_HUNT && offset_q == 16'd0)
		else $error("end of buffer did not restart hunting");

	a_start_inside_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		has_result && res.error_code == ERR_START_INSIDE |-> !res.field_done)
		else $error("field closed on start delimiter");
`endif

endmodule

[hdl/nsfs_out_reg.sv]
module nsfs_out_reg
	import nsfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    ready,
	output logic    valid,
	output result_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign valid = valid_q;

endmodule

[hdl/nmea_sentence_field_splitter.sv]
// nmea sentence field splitter
// input channel: in_valid/in_ready carry one buffer byte (data_byte) and a flag
// (end_of_buffer) on the buffer's last byte
// output channel: out_valid/out_ready carry one result per byte that closes a
// field (',' or '*'), ends the buffer outside the drop after an error, or stops
// parsing with an error; other bytes give no output transaction
// path: an accepted byte waits in the input register; its result is formed when
// the byte steps and is held in the result register that drives the outputs
// throughput: one byte per cycle while out_ready is high; the per-byte state
// update is a single combinational pass between the two registers
// stall: while a result waits, one more byte can sit in the input register;
// when that byte needs the busy result register, in_ready drops until the
// result is taken; bytes that give no result keep flowing
// reset: arst_n clears both registers' valid flags and puts the parser back to
// hunting for '$' with a zero byte offset
// after an error bytes are dropped up to and including end_of_buffer
module nmea_sentence_field_splitter
	import nsfs_pkg::*;
#(
	parameter int MAX_FIELDS = DEFAULT_MAX_FIELDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        field_done,
	output logic [4:0]  field_number,
	output logic [15:0] field_start,
	output logic [7:0]  field_length,
	output logic        sentence_done,
	output logic        parse_ok,
	output logic [2:0]  error_code,
	output logic [4:0]  last_field_index,
	output logic [7:0]  received_sum,
	output logic [7:0]  computed_sum
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       step;
	logic       has_result;
	result_t    res_d, res_q;

	// a byte with no result may retire even while the output is stalled
	always_comb begin
		step     = valid_s1 && (!has_result || !out_valid || out_ready);
		in_ready = !valid_s1 || step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	nsfs_core #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (byte_s1),
		.end_of_buffer(eob_s1),
		.has_result   (has_result),
		.res          (res_d)
	);

	nsfs_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (step && has_result),
		.res_in(res_d),
		.ready (out_ready),
		.valid (out_valid),
		.res_q (res_q)
	);

	assign field_done       = res_q.field_done;
	assign field_number     = res_q.field_number;
	assign field_start      = res_q.field_start;
	assign field_length     = res_q.field_length;
	assign sentence_done    = res_q.sentence_done;
	assign parse_ok         = res_q.parse_ok;
	assign error_code       = res_q.error_code;
	assign last_field_index = res_q.last_field_index;
	assign received_sum     = res_q.received_sum;
	assign computed_sum     = res_q.computed_sum;

endmodule

[verif/testbench.sv]
module testbench;
	import nsfs_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int BYTES_PER_PHASE = 330;

	// tracks the splitter's parse state and the reports it still owes
	class field_scoreboard;
		typedef enum logic [2:0] {HUNT, PAYLOAD, DIGIT_HI, DIGIT_LO, DROP} phase_t;

		phase_t phase;
		logic [7:0] run_xor;
		logic [7:0] held_xor;
		logic [7:0] sum_rx;
		logic [3:0] hi_nibble;
		logic hi_bad;
		int unsigned field_idx;
		logic [7:0] field_len;
		logic [15:0] field_pos;
		logic [15:0] offset;
		result_t pending_reports[$];
		int unsigned failures;

		function new();
			phase = HUNT;
			offset = 16'd0;
			failures = 0;
			clear_sentence();
		endfunction

		function void clear_sentence();
			run_xor = 8'd0;
			held_xor = 8'hFF;
			sum_rx = 8'd0;
			hi_nibble = 4'd0;
			hi_bad = 1'b0;
			field_idx = 0;
			field_len = 8'd0;
			field_pos = 16'd0;
		endfunction

		function logic [15:0] bump(input logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function logic decode_hex(input logic [7:0] c, output logic [3:0] v);
			v = 4'd0;
			decode_hex = 1'b1;
			if (c >= "0" && c <= "9") begin
				v = 4'(c - "0");
			end else if (c >= "A" && c <= "F") begin
				v = 4'(c - "A" + 8'd10);
			end else if (c >= "a" && c <= "f") begin
				v = 4'(c - "a" + 8'd10);
			end else begin
				decode_hex = 1'b0;
			end
		endfunction

		function void note_byte(input logic [7:0] c, input logic eob);
			logic [15:0] pos;
			logic [3:0] nib;
			logic ok_hex;
			logic closed;
			logic ended;
			err_t err;
			result_t r;
			pos = offset;
			offset = bump(offset);
			closed = 1'b0;
			ended = 1'b0;
			err = ERR_NONE;
			r = '0;
			case (phase)
			HUNT: begin
				if (c == CH_START) begin
					clear_sentence();
					field_pos = bump(pos);
					phase = PAYLOAD;
					ended = eob;
				end else if (eob) begin
					ended = 1'b1;
					err = ERR_NO_START;
				end
			end
			PAYLOAD: begin
				if (c == CH_START) begin
					ended = 1'b1;
					err = ERR_START_INSIDE;
				end else if (c == CH_CHECK || c == CH_SEP) begin
					closed = 1'b1;
					r.field_number = field_idx[4:0];
					r.field_start = field_pos;
					r.field_length = field_len;
					if (c == CH_CHECK) begin
						if (eob) begin
							ended = 1'b1;
							err = ERR_CHECKSUM_TRUNC;
						end else begin
							phase = DIGIT_HI;
						end
					end else begin
						run_xor ^= c;
						if (eob) begin
							ended = 1'b1;
						end else begin
							field_idx++;
							if (field_idx >= DEFAULT_MAX_FIELDS) begin
								field_idx = DEFAULT_MAX_FIELDS;
								ended = 1'b1;
								err = ERR_TOO_MANY;
							end else begin
								field_pos = bump(pos);
								field_len = 8'd0;
							end
						end
					end
				end else begin
					if (field_len != 8'hFF) field_len++;
					run_xor ^= c;
					ended = eob;
				end
			end
			DIGIT_HI: begin
				if (eob) begin
					ended = 1'b1;
					err = ERR_CHECKSUM_TRUNC;
				end else begin
					hi_bad = !decode_hex(c, hi_nibble);
					phase = DIGIT_LO;
				end
			end
			DIGIT_LO: begin
				ok_hex = decode_hex(c, nib);
				if (eob) begin
					ended = 1'b1;
					err = ERR_CHECKSUM_TRUNC;
				end else if (hi_bad || !ok_hex) begin
					ended = 1'b1;
					err = ERR_NON_HEX;
				end else begin
					sum_rx = {hi_nibble, nib};
					// the low digit still goes into the running xor
					held_xor = run_xor;
					run_xor ^= c;
					phase = PAYLOAD;
				end
			end
			default: ;
			endcase
			if (ended && err != ERR_NONE) phase = DROP;
			if (eob) begin
				phase = HUNT;
				offset = 16'd0;
			end
			if (closed || ended) begin
				r.field_done = closed;
				r.sentence_done = ended;
				r.parse_ok = ended && err == ERR_NONE;
				r.error_code = err;
				if (ended) begin
					r.last_field_index = field_idx[4:0];
					r.received_sum = sum_rx;
					r.computed_sum = held_xor;
				end
				pending_reports.push_back(r);
			end
		endfunction

		function void compare(input string name, input logic [15:0] want,
			input logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_report(input result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result, field_done %0h sentence_done %0h error_code %0h",
					$time, got.field_done, got.sentence_done, got.error_code);
				failures++;
				return;
			end
			want = pending_reports.pop_front();
			compare("field_done", 16'(want.field_done), 16'(got.field_done));
			compare("field_number", 16'(want.field_number), 16'(got.field_number));
			compare("field_start", want.field_start, got.field_start);
			compare("field_length", 16'(want.field_length), 16'(got.field_length));
			compare("sentence_done", 16'(want.sentence_done), 16'(got.sentence_done));
			compare("parse_ok", 16'(want.parse_ok), 16'(got.parse_ok));
			compare("error_code", 16'(want.error_code), 16'(got.error_code));
			compare("last_field_index", 16'(want.last_field_index),
				16'(got.last_field_index));
			compare("received_sum", 16'(want.received_sum), 16'(got.received_sum));
			compare("computed_sum", 16'(want.computed_sum), 16'(got.computed_sum));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic end_of_buffer = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic field_done;
	logic [4:0] field_number;
	logic [15:0] field_start;
	logic [7:0] field_length;
	logic sentence_done;
	logic parse_ok;
	logic [2:0] error_code;
	logic [4:0] last_field_index;
	logic [7:0] received_sum;
	logic [7:0] computed_sum;

	field_scoreboard sb = new();
	result_t seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic [7:0] line_bytes[$];
	string directed_lines[$] = '{"$", "$A,", "$*", "$*1", "$*1f", "$*g0x", "$$x",
		"$A,*aF\n"};

	nmea_sentence_field_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_done(field_done),
		.field_number(field_number),
		.field_start(field_start),
		.field_length(field_length),
		.sentence_done(sentence_done),
		.parse_ok(parse_ok),
		.error_code(error_code),
		.last_field_index(last_field_index),
		.received_sum(received_sum),
		.computed_sum(computed_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.field_done = field_done;
			seen.field_number = field_number;
			seen.field_start = field_start;
			seen.field_length = field_length;
			seen.sentence_done = sentence_done;
			seen.parse_ok = parse_ok;
			seen.error_code = err_t'(error_code);
			seen.last_field_index = last_field_index;
			seen.received_sum = received_sum;
			seen.computed_sum = computed_sum;
			sb.check_report(seen);
		end
	end

	function automatic logic [7:0] payload_char();
		logic [7:0] c;
		case ($urandom_range(0, 4))
		0: c = 8'("0" + $urandom_range(0, 9));
		1, 2: c = 8'("A" + $urandom_range(0, 25));
		3: c = $urandom_range(0, 1) ? "." : "-";
		default: begin
			c = 8'($urandom_range(0, 255));
			while (c == CH_START || c == CH_CHECK || c == CH_SEP) c = 8'($urandom_range(0, 255));
		end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return "0" + 8'(n);
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 3))
		0: return CH_START;
		1: return CH_CHECK;
		2: return CH_SEP;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// random sentence after junk_len noise bytes; its checksum can be wrong or absent
	function automatic void build_sentence(input int junk_len);
		int nfields;
		int len;
		logic [7:0] sum;
		logic [7:0] c;
		line_bytes.delete();
		repeat (junk_len) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_START) c = "X";
			line_bytes.push_back(c);
		end
		line_bytes.push_back(CH_START);
		sum = 8'd0;
		nfields = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 9);
		for (int f = 0; f < nfields; f++) begin
			if (f != 0) begin
				line_bytes.push_back(CH_SEP);
				sum ^= CH_SEP;
			end
			len = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 7);
			repeat (len) begin
				c = payload_char();
				line_bytes.push_back(c);
				sum ^= c;
			end
		end
		case ($urandom_range(0, 5))
		0: ;
		1: line_bytes.push_back(CH_SEP);
		default: begin
			line_bytes.push_back(CH_CHECK);
			if ($urandom_range(0, 3) == 0) sum = 8'($urandom_range(0, 255));
			line_bytes.push_back(hex_char(sum[7:4]));
			line_bytes.push_back(hex_char(sum[3:0]));
			// text after the checksum keeps counting into the starred field
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(0, 3)) line_bytes.push_back(payload_char());
				line_bytes.push_back(CH_SEP);
			end
			line_bytes.push_back(8'h0D);
			line_bytes.push_back(8'h0A);
		end
		endcase
	endfunction

	function automatic void build_broken();
		case ($urandom_range(0, 2))
		0: begin
			line_bytes.delete();
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 3))
				0: line_bytes.push_back(special_char());
				1: line_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
				default: line_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		1: begin
			build_sentence($urandom_range(0, 1));
			line_bytes = line_bytes[0:$urandom_range(0, line_bytes.size() - 1)];
		end
		default: begin
			build_sentence($urandom_range(0, 1));
			line_bytes[$urandom_range(0, line_bytes.size() - 1)] = special_char();
		end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eob);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, eob);
	endtask

	task automatic send_line();
		foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		string s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 3; p++) begin
			case (p)
			0: begin
				send_idle_pct = 31;
				recv_idle_pct = 65;
			end
			1: begin
				send_idle_pct = 65;
				recv_idle_pct = 31;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			endcase
			if (p == 0) begin
				line_bytes = '{8'h00, 8'hFF};
				send_line();
				foreach (directed_lines[k]) begin
					s = directed_lines[k];
					line_bytes.delete();
					for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
					send_line();
				end
			end
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				if ($urandom_range(0, 3) == 0) build_broken();
				else build_sentence($urandom_range(0, 3));
				send_line();
				sent += line_bytes.size();
			end
			wait_for_results();
		end
		if (sb.failures == 0)
			$display("nmea_sentence_field_splitter regression: pass");
		else
			$display("nmea_sentence_field_splitter regression: fail");
		$finish;
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("nmea_sentence_field_splitter regression: fail");
		$finish;
	end
endmodule
